// ===== hdl/assert_macros.svh =====
// assertion macros used by the rtl top file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define Q2PM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define Q2PM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/q2pm_pkg.sv =====
// types, constants and rounding functions for the quaternion to pose matrix block
package q2pm_pkg;

    localparam int QW   = 16;
    localparam int PW   = 32;
    localparam int RW   = 18;
    localparam int PRW  = 2 * QW;
    localparam int EW   = 35;
    localparam int MW   = PW + RW;
    localparam int AW   = MW + 3;

    typedef logic signed [QW-1:0]  t_quat;
    typedef logic signed [PW-1:0]  t_pos;
    typedef logic signed [RW-1:0]  t_rot;
    typedef logic signed [PRW-1:0] t_prod;
    typedef logic signed [EW-1:0]  t_entry;
    typedef logic signed [MW-1:0]  t_tprod;
    typedef logic signed [AW-1:0]  t_acc;

    localparam t_entry ONE_Q30 = t_entry'(64'sd1073741824);

    // q30 entry to q2.16, round half up, saturate
    function automatic t_rot round_sat_rot(input t_entry v);
        t_entry                 b;
        logic signed [EW-15:0]  s;
        t_rot                   r;
        b = v + t_entry'(64'sd8192);
        s = (EW-14)'(b >>> 14);
        if (s > (EW-14)'(64'sd131071)) begin
            r = t_rot'(64'sd131071);
        end else if (s < (EW-14)'(-64'sd131072)) begin
            r = t_rot'(-64'sd131072);
        end else begin
            r = t_rot'(s);
        end
        return r;
    endfunction

    // minus q32 sum to q16.16, round half up, saturate
    function automatic t_pos neg_round_sat_pos(input t_acc acc);
        t_acc                   n;
        logic signed [AW-17:0]  s;
        t_pos                   r;
        n = t_acc'(64'sd32768) - acc;
        s = (AW-16)'(n >>> 16);
        if (s > (AW-16)'(64'sd2147483647)) begin
            r = t_pos'(64'sd2147483647);
        end else if (s < (AW-16)'(-64'sd2147483648)) begin
            r = t_pos'(-64'sd2147483648);
        end else begin
            r = t_pos'(s);
        end
        return r;
    endfunction

endpackage

// ===== hdl/quaternion_to_pose_matrix_top.sv =====
// quaternion and position to 4x4 pose matrix or rigid inverse, six stage pipeline
//
//  channel   handshake              payload
//  request   start / busy           i_req_type, i_quat_x..w, i_pos_x..z
//  result    o_valid (1 cycle)      o_rot_00..o_rot_22, o_trans_x..z
//
// one word accepted per cycle while busy is low, result on o_valid from the output register
// stages: input reg, quat products, rotation round/sat, position products,
// column sums, negate/round/sat and transpose select
// busy is high only while reset is held; reset clears the valid bits
// the receiver cannot stall, so nothing in the pipeline ever waits
`include "assert_macros.svh"

module quaternion_to_pose_matrix_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_req_type,
    input  q2pm_pkg::t_quat       i_quat_x,
    input  q2pm_pkg::t_quat       i_quat_y,
    input  q2pm_pkg::t_quat       i_quat_z,
    input  q2pm_pkg::t_quat       i_quat_w,
    input  q2pm_pkg::t_pos        i_pos_x,
    input  q2pm_pkg::t_pos        i_pos_y,
    input  q2pm_pkg::t_pos        i_pos_z,
    output logic                  o_valid,
    output q2pm_pkg::t_rot        o_rot_00,
    output q2pm_pkg::t_rot        o_rot_01,
    output q2pm_pkg::t_rot        o_rot_02,
    output q2pm_pkg::t_rot        o_rot_10,
    output q2pm_pkg::t_rot        o_rot_11,
    output q2pm_pkg::t_rot        o_rot_12,
    output q2pm_pkg::t_rot        o_rot_20,
    output q2pm_pkg::t_rot        o_rot_21,
    output q2pm_pkg::t_rot        o_rot_22,
    output q2pm_pkg::t_pos        o_trans_x,
    output q2pm_pkg::t_pos        o_trans_y,
    output q2pm_pkg::t_pos        o_trans_z
);

    // stage 1: input register
    logic               r_v1, r_inv1;
    q2pm_pkg::t_quat    r_qx1, r_qy1, r_qz1, r_qw1;
    q2pm_pkg::t_pos     r_p1 [3];

    // stage 2: quaternion products
    logic               r_v2, r_inv2;
    q2pm_pkg::t_prod    r_xx, r_yy, r_zz, r_xy, r_zw, r_xz, r_yw, r_yz, r_xw;
    q2pm_pkg::t_pos     r_p2 [3];

    // stage 3: rotation, r[col][row]
    logic               r_v3, r_inv3;
    q2pm_pkg::t_rot     r_rot3 [3][3];
    q2pm_pkg::t_rot     n_rot3 [3][3];
    q2pm_pkg::t_pos     r_p3 [3];

    // stage 4: position times rotation column
    logic               r_v4, r_inv4;
    q2pm_pkg::t_rot     r_rot4 [3][3];
    q2pm_pkg::t_pos     r_p4 [3];
    q2pm_pkg::t_tprod   r_m4 [3][3];
    q2pm_pkg::t_tprod   n_m4 [3][3];

    // stage 5: column sums
    logic               r_v5, r_inv5;
    q2pm_pkg::t_rot     r_rot5 [3][3];
    q2pm_pkg::t_pos     r_p5 [3];
    q2pm_pkg::t_acc     r_acc5 [3];
    q2pm_pkg::t_acc     n_acc5 [3];

    // stage 6: output register
    logic               r_valid, r_inv6;
    q2pm_pkg::t_rot     r_out_rot [3][3];
    q2pm_pkg::t_rot     n_out_rot [3][3];
    q2pm_pkg::t_pos     r_out_trans [3];
    q2pm_pkg::t_pos     n_out_trans [3];

    logic               accept;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_v1    <= accept;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
            r_valid <= r_v5;
        end
    end

    always_comb begin
        n_rot3[0][0] = q2pm_pkg::round_sat_rot(q2pm_pkg::ONE_Q30
                       - ((q2pm_pkg::t_entry'(r_yy) + q2pm_pkg::t_entry'(r_zz)) <<< 1));
        n_rot3[1][1] = q2pm_pkg::round_sat_rot(q2pm_pkg::ONE_Q30
                       - ((q2pm_pkg::t_entry'(r_xx) + q2pm_pkg::t_entry'(r_zz)) <<< 1));
        n_rot3[2][2] = q2pm_pkg::round_sat_rot(q2pm_pkg::ONE_Q30
                       - ((q2pm_pkg::t_entry'(r_xx) + q2pm_pkg::t_entry'(r_yy)) <<< 1));
        n_rot3[1][0] = q2pm_pkg::round_sat_rot(
                       (q2pm_pkg::t_entry'(r_xy) + q2pm_pkg::t_entry'(r_zw)) <<< 1);
        n_rot3[0][1] = q2pm_pkg::round_sat_rot(
                       (q2pm_pkg::t_entry'(r_xy) - q2pm_pkg::t_entry'(r_zw)) <<< 1);
        n_rot3[2][0] = q2pm_pkg::round_sat_rot(
                       (q2pm_pkg::t_entry'(r_xz) - q2pm_pkg::t_entry'(r_yw)) <<< 1);
        n_rot3[0][2] = q2pm_pkg::round_sat_rot(
                       (q2pm_pkg::t_entry'(r_xz) + q2pm_pkg::t_entry'(r_yw)) <<< 1);
        n_rot3[2][1] = q2pm_pkg::round_sat_rot(
                       (q2pm_pkg::t_entry'(r_yz) + q2pm_pkg::t_entry'(r_xw)) <<< 1);
        n_rot3[1][2] = q2pm_pkg::round_sat_rot(
                       (q2pm_pkg::t_entry'(r_yz) - q2pm_pkg::t_entry'(r_xw)) <<< 1);
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) begin
                n_m4[c][k] = r_p3[k] * r_rot3[c][k];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_acc5[c] = q2pm_pkg::t_acc'(r_m4[c][0]) + q2pm_pkg::t_acc'(r_m4[c][1])
                      + q2pm_pkg::t_acc'(r_m4[c][2]);
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) begin
                n_out_rot[c][k] = r_inv5 ? r_rot5[k][c] : r_rot5[c][k];
            end
            n_out_trans[c] = r_inv5 ? q2pm_pkg::neg_round_sat_pos(r_acc5[c]) : r_p5[c];
        end
    end

    always_ff @(posedge i_clk) begin
        r_inv1 <= i_req_type;
        r_qx1  <= i_quat_x;
        r_qy1  <= i_quat_y;
        r_qz1  <= i_quat_z;
        r_qw1  <= i_quat_w;
        r_p1[0] <= i_pos_x;
        r_p1[1] <= i_pos_y;
        r_p1[2] <= i_pos_z;

        r_inv2 <= r_inv1;
        r_xx   <= r_qx1 * r_qx1;
        r_yy   <= r_qy1 * r_qy1;
        r_zz   <= r_qz1 * r_qz1;
        r_xy   <= r_qx1 * r_qy1;
        r_zw   <= r_qz1 * r_qw1;
        r_xz   <= r_qx1 * r_qz1;
        r_yw   <= r_qy1 * r_qw1;
        r_yz   <= r_qy1 * r_qz1;
        r_xw   <= r_qx1 * r_qw1;
        r_p2   <= r_p1;

        r_inv3 <= r_inv2;
        r_rot3 <= n_rot3;
        r_p3   <= r_p2;

        r_inv4 <= r_inv3;
        r_rot4 <= r_rot3;
        r_p4   <= r_p3;
        r_m4   <= n_m4;

        r_inv5 <= r_inv4;
        r_rot5 <= r_rot4;
        r_p5   <= r_p4;
        r_acc5 <= n_acc5;

        r_inv6      <= r_inv5;
        r_out_rot   <= n_out_rot;
        r_out_trans <= n_out_trans;
    end

    assign o_valid   = r_valid;
    assign o_rot_00  = r_out_rot[0][0];
    assign o_rot_01  = r_out_rot[0][1];
    assign o_rot_02  = r_out_rot[0][2];
    assign o_rot_10  = r_out_rot[1][0];
    assign o_rot_11  = r_out_rot[1][1];
    assign o_rot_12  = r_out_rot[1][2];
    assign o_rot_20  = r_out_rot[2][0];
    assign o_rot_21  = r_out_rot[2][1];
    assign o_rot_22  = r_out_rot[2][2];
    assign o_trans_x = r_out_trans[0];
    assign o_trans_y = r_out_trans[1];
    assign o_trans_z = r_out_trans[2];

    `Q2PM_ASSERT_IMP(a_latency, i_clk, i_rst_n, o_valid, $past(start && !busy, 6), "result without a request six cycles earlier")
    `Q2PM_ASSERT_IMP(a_diag_kept, i_clk, i_rst_n, o_valid, o_rot_11 == $past(r_rot3[1][1], 3), "diagonal entry changed after rounding")
    `Q2PM_ASSERT_IMP(a_transpose, i_clk, i_rst_n, o_valid && r_inv6, o_rot_01 == $past(r_rot3[1][0], 3), "inverse rotation not transposed")
    `Q2PM_ASSERT_NEXT(a_pose_pos, i_clk, i_rst_n, r_v5 && !r_inv5, o_trans_y == $past(r_p5[1]), "object pose position not passed through")

endmodule

// ===== tb/quaternion_to_pose_matrix_top_tb.sv =====
// testbench for quaternion_to_pose_matrix_top: directed and random poses checked against a predictor
`timescale 1ns / 100ps

module quaternion_to_pose_matrix_top_tb;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        q2pm_pkg::t_rot rot_00, rot_01, rot_02;
        q2pm_pkg::t_rot rot_10, rot_11, rot_12;
        q2pm_pkg::t_rot rot_20, rot_21, rot_22;
        q2pm_pkg::t_pos trans_x, trans_y, trans_z;
    } t_pose_word;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    logic            i_req_type;
    q2pm_pkg::t_quat i_quat_x, i_quat_y, i_quat_z, i_quat_w;
    q2pm_pkg::t_pos  i_pos_x, i_pos_y, i_pos_z;
    logic            o_valid;
    q2pm_pkg::t_rot  o_rot_00, o_rot_01, o_rot_02;
    q2pm_pkg::t_rot  o_rot_10, o_rot_11, o_rot_12;
    q2pm_pkg::t_rot  o_rot_20, o_rot_21, o_rot_22;
    q2pm_pkg::t_pos  o_trans_x, o_trans_y, o_trans_z;

    t_pose_word pending_poses[$];
    int idle_pct;
    int words_sent;
    int inverse_sent;
    int words_checked;
    int mismatches;
    int cycles;
    string field_names [12] = '{"rot_00", "rot_01", "rot_02", "rot_10", "rot_11", "rot_12",
                                "rot_20", "rot_21", "rot_22", "trans_x", "trans_y", "trans_z"};

    quaternion_to_pose_matrix_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req_type (i_req_type),
        .i_quat_x   (i_quat_x),
        .i_quat_y   (i_quat_y),
        .i_quat_z   (i_quat_z),
        .i_quat_w   (i_quat_w),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pos_z    (i_pos_z),
        .o_valid    (o_valid),
        .o_rot_00   (o_rot_00),
        .o_rot_01   (o_rot_01),
        .o_rot_02   (o_rot_02),
        .o_rot_10   (o_rot_10),
        .o_rot_11   (o_rot_11),
        .o_rot_12   (o_rot_12),
        .o_rot_20   (o_rot_20),
        .o_rot_21   (o_rot_21),
        .o_rot_22   (o_rot_22),
        .o_trans_x  (o_trans_x),
        .o_trans_y  (o_trans_y),
        .o_trans_z  (o_trans_z)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint rot_round_sat(input longint v);
        longint s;
        s = (v + 64'sd8192) >>> 14;
        if (s > 64'sd131071) begin
            s = 64'sd131071;
        end else if (s < -64'sd131072) begin
            s = -64'sd131072;
        end
        return s;
    endfunction

    function automatic t_pose_word compute_pose(input logic inv, input q2pm_pkg::t_quat qx,
                                                input q2pm_pkg::t_quat qy,
                                                input q2pm_pkg::t_quat qz,
                                                input q2pm_pkg::t_quat qw,
                                                input q2pm_pkg::t_pos px,
                                                input q2pm_pkg::t_pos py,
                                                input q2pm_pkg::t_pos pz);
        longint x, y, z, w;
        longint p [3];
        longint r [3][3];
        longint t [3];
        longint acc, s, tmp;
        int c, k;
        t_pose_word o;
        x = qx;
        y = qy;
        z = qz;
        w = qw;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        // r[col][row]
        r[0][0] = rot_round_sat(longint'(q2pm_pkg::ONE_Q30) - 2 * (y * y + z * z));
        r[1][1] = rot_round_sat(longint'(q2pm_pkg::ONE_Q30) - 2 * (x * x + z * z));
        r[2][2] = rot_round_sat(longint'(q2pm_pkg::ONE_Q30) - 2 * (x * x + y * y));
        r[1][0] = rot_round_sat(2 * (x * y + z * w));
        r[0][1] = rot_round_sat(2 * (x * y - z * w));
        r[2][0] = rot_round_sat(2 * (x * z - y * w));
        r[0][2] = rot_round_sat(2 * (x * z + y * w));
        r[2][1] = rot_round_sat(2 * (y * z + x * w));
        r[1][2] = rot_round_sat(2 * (y * z - x * w));
        if (inv) begin
            for (c = 0; c < 3; c++) begin
                acc = p[0] * r[c][0] + p[1] * r[c][1] + p[2] * r[c][2];
                s = (64'sd32768 - acc) >>> 16;
                if (s > 64'sd2147483647) begin
                    s = 64'sd2147483647;
                end else if (s < -64'sd2147483648) begin
                    s = -64'sd2147483648;
                end
                t[c] = s;
            end
            for (c = 0; c < 3; c++) begin
                for (k = c + 1; k < 3; k++) begin
                    tmp = r[c][k];
                    r[c][k] = r[k][c];
                    r[k][c] = tmp;
                end
            end
        end else begin
            t = p;
        end
        o.rot_00 = q2pm_pkg::t_rot'(r[0][0]);
        o.rot_01 = q2pm_pkg::t_rot'(r[0][1]);
        o.rot_02 = q2pm_pkg::t_rot'(r[0][2]);
        o.rot_10 = q2pm_pkg::t_rot'(r[1][0]);
        o.rot_11 = q2pm_pkg::t_rot'(r[1][1]);
        o.rot_12 = q2pm_pkg::t_rot'(r[1][2]);
        o.rot_20 = q2pm_pkg::t_rot'(r[2][0]);
        o.rot_21 = q2pm_pkg::t_rot'(r[2][1]);
        o.rot_22 = q2pm_pkg::t_rot'(r[2][2]);
        o.trans_x = q2pm_pkg::t_pos'(t[0]);
        o.trans_y = q2pm_pkg::t_pos'(t[1]);
        o.trans_z = q2pm_pkg::t_pos'(t[2]);
        return o;
    endfunction

    // entered and left at a falling edge
    task automatic send_pose(input logic inv, input q2pm_pkg::t_quat qx,
                             input q2pm_pkg::t_quat qy, input q2pm_pkg::t_quat qz,
                             input q2pm_pkg::t_quat qw, input q2pm_pkg::t_pos px,
                             input q2pm_pkg::t_pos py, input q2pm_pkg::t_pos pz);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start      <= 1'b1;
        i_req_type <= inv;
        i_quat_x   <= qx;
        i_quat_y   <= qy;
        i_quat_z   <= qz;
        i_quat_w   <= qw;
        i_pos_x    <= px;
        i_pos_y    <= py;
        i_pos_z    <= pz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_poses.push_back(compute_pose(inv, qx, qy, qz, qw, px, py, pz));
        words_sent++;
        if (inv) begin
            inverse_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic test_special_rotations();
        idle_pct = 0;
        send_pose(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 32'sd98304, -32'sd147456, 32'sd196608);
        send_pose(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 32'sd98304, -32'sd147456, 32'sd196608);
        send_pose(1'b1, 16'sd0, 16'sd0, 16'sd0, -16'sd32768, -32'sd65536, 32'sd0, 32'sd65536);
        send_pose(1'b0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0, 32'sd65536, 32'sd131072, 32'sd0);
        send_pose(1'b1, 16'sd0, 16'sd32767, 16'sd0, 16'sd0, 32'sd65536, 32'sd131072, 32'sd0);
        send_pose(1'b1, 16'sd0, 16'sd0, 16'sd32767, 16'sd0, 32'sd65536, 32'sd131072, -32'sd1);
        send_pose(1'b1, 16'sd0, 16'sd0, 16'sd23170, 16'sd23170, 32'sd327680, -32'sd65536, 32'sd1);
        send_pose(1'b0, 16'sd23170, 16'sd0, 16'sd0, -16'sd23170, 32'sd0, 32'sd0, 32'sd0);
        send_pose(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'sd12345, -32'sd54321, 32'sd1);
    endtask

    task automatic test_saturation();
        idle_pct = 0;
        send_pose(1'b0, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                  32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_pose(1'b1, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                  32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_pose(1'b1, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                  q2pm_pkg::t_pos'(32'h8000_0000), q2pm_pkg::t_pos'(32'h8000_0000),
                  q2pm_pkg::t_pos'(32'h8000_0000));
        send_pose(1'b1, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                  32'sh7fff_ffff, q2pm_pkg::t_pos'(32'h8000_0000), 32'sh7fff_ffff);
        send_pose(1'b1, -16'sd32768, -16'sd32768, 16'sd0, 16'sd0,
                  q2pm_pkg::t_pos'(32'h8000_0000), 32'sh7fff_ffff,
                  q2pm_pkg::t_pos'(32'h8000_0000));
        send_pose(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd32767,
                  q2pm_pkg::t_pos'(32'h8000_0000), 32'sh7fff_ffff,
                  q2pm_pkg::t_pos'(32'h8000_0000));
        send_pose(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                  32'sh7fff_ffff, q2pm_pkg::t_pos'(32'h8000_0000), 32'sh7fff_ffff);
        send_pose(1'b0, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
                  q2pm_pkg::t_pos'(32'h8000_0000), 32'sh7fff_ffff,
                  q2pm_pkg::t_pos'(32'h8000_0000));
    endtask

    task automatic test_bit_patterns();
        idle_pct = 0;
        send_pose(1'b1, q2pm_pkg::t_quat'(16'h5555), q2pm_pkg::t_quat'(16'haaaa),
                  q2pm_pkg::t_quat'(16'h5555), q2pm_pkg::t_quat'(16'haaaa),
                  q2pm_pkg::t_pos'(32'h5555_5555), q2pm_pkg::t_pos'(32'haaaa_aaaa),
                  q2pm_pkg::t_pos'(32'h5555_5555));
        send_pose(1'b0, q2pm_pkg::t_quat'(16'haaaa), q2pm_pkg::t_quat'(16'h5555),
                  q2pm_pkg::t_quat'(16'haaaa), q2pm_pkg::t_quat'(16'h5555),
                  q2pm_pkg::t_pos'(32'haaaa_aaaa), q2pm_pkg::t_pos'(32'h5555_5555),
                  q2pm_pkg::t_pos'(32'haaaa_aaaa));
        send_pose(1'b1, q2pm_pkg::t_quat'(16'hffff), q2pm_pkg::t_quat'(16'h0001),
                  q2pm_pkg::t_quat'(16'h8001), q2pm_pkg::t_quat'(16'h7ffe),
                  q2pm_pkg::t_pos'(32'hffff_ffff), q2pm_pkg::t_pos'(32'h0000_0001),
                  q2pm_pkg::t_pos'(32'h8000_0001));
    endtask

    task automatic test_random_poses(input int count, input int pct);
        real comp [4];
        real norm;
        q2pm_pkg::t_quat q [4];
        q2pm_pkg::t_pos p [3];
        int kind, n, i;
        idle_pct = pct;
        for (n = 0; n < count; n++) begin
            kind = $urandom_range(99);
            if (kind < 60) begin
                // unit quaternion with random direction
                norm = 0.0;
                for (i = 0; i < 4; i++) begin
                    comp[i] = int'($urandom_range(65535)) - 32768;
                    norm = norm + comp[i] * comp[i];
                end
                if (norm == 0.0) begin
                    comp[3] = 1.0;
                    norm = 1.0;
                end
                norm = $sqrt(norm);
                for (i = 0; i < 4; i++) begin
                    comp[i] = comp[i] * 32767.0 / norm;
                    q[i] = q2pm_pkg::t_quat'($rtoi(comp[i] >= 0.0 ? comp[i] + 0.5
                                                                  : comp[i] - 0.5));
                end
            end else if (kind < 85) begin
                for (i = 0; i < 4; i++) begin
                    q[i] = q2pm_pkg::t_quat'($urandom);
                end
            end else begin
                for (i = 0; i < 4; i++) begin
                    case ($urandom_range(4))
                        0: q[i] = q2pm_pkg::t_quat'(-32768);
                        1: q[i] = q2pm_pkg::t_quat'(32767);
                        2: q[i] = q2pm_pkg::t_quat'(0);
                        3: q[i] = q2pm_pkg::t_quat'(1);
                        default: q[i] = q2pm_pkg::t_quat'(-1);
                    endcase
                end
            end
            for (i = 0; i < 3; i++) begin
                kind = $urandom_range(99);
                if (kind < 50) begin
                    p[i] = q2pm_pkg::t_pos'(int'($urandom_range(2097151)) - 1048576);
                end else if (kind < 85) begin
                    p[i] = q2pm_pkg::t_pos'($urandom);
                end else begin
                    case ($urandom_range(4))
                        0: p[i] = q2pm_pkg::t_pos'(32'h7fff_ffff);
                        1: p[i] = q2pm_pkg::t_pos'(32'h8000_0000);
                        2: p[i] = q2pm_pkg::t_pos'(0);
                        3: p[i] = q2pm_pkg::t_pos'(65536);
                        default: p[i] = q2pm_pkg::t_pos'(-65536);
                    endcase
                end
            end
            send_pose(1'($urandom_range(1)), q[0], q[1], q[2], q[3], p[0], p[1], p[2]);
        end
    endtask

    always @(posedge i_clk) begin : word_check
        t_pose_word want;
        longint want_f [12];
        longint got_f [12];
        int i;
        if (o_valid === 1'b1) begin
            if (pending_poses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word with nothing pending");
                end
            end else begin
                want = pending_poses.pop_front();
                want_f = '{want.rot_00, want.rot_01, want.rot_02, want.rot_10, want.rot_11,
                           want.rot_12, want.rot_20, want.rot_21, want.rot_22, want.trans_x,
                           want.trans_y, want.trans_z};
                got_f = '{o_rot_00, o_rot_01, o_rot_02, o_rot_10, o_rot_11, o_rot_12,
                          o_rot_20, o_rot_21, o_rot_22, o_trans_x, o_trans_y, o_trans_z};
                for (i = 0; i < 12; i++) begin
                    if (want_f[i] != got_f[i]) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("word %0d %s mismatch: expected %0d got %0d",
                                     words_checked, field_names[i], want_f[i], got_f[i]);
                        end
                    end
                end
                words_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words pending", cycles, pending_poses.size());
            $display("quaternion_to_pose_matrix_top verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req_type = 1'b0;
        i_quat_x   = '0;
        i_quat_y   = '0;
        i_quat_z   = '0;
        i_quat_w   = '0;
        i_pos_x    = '0;
        i_pos_y    = '0;
        i_pos_z    = '0;
        idle_pct   = 0;
        words_sent = 0;
        inverse_sent  = 0;
        words_checked = 0;
        mismatches = 0;
        cycles     = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_special_rotations();
        test_saturation();
        test_bit_patterns();
        test_random_poses(320, 27);
        test_random_poses(320, 50);
        test_random_poses(310, 0);
        start <= 1'b0;
        while (pending_poses.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        $display("covered %0d pose words (%0d camera inverses) at sender idle rates 27, 50, 0",
                 words_sent, inverse_sent);
        $display("checked %0d result words, %0d field mismatches", words_checked, mismatches);
        if (mismatches == 0) begin
            $display("quaternion_to_pose_matrix_top verification clean");
        end else begin
            $display("quaternion_to_pose_matrix_top verification failed");
        end
        $finish;
    end

endmodule
